### rtl/aph_pkg.sv
// shared constants, command and register codes, and controller/datapath signal groups
// for the playhead timer; no dependencies
package aph_pkg;

  localparam int unsigned TIME_BITS_DEF = 24;

  localparam int unsigned CMD_W      = 3;
  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned FRAC_W     = 17;
  localparam int unsigned POS_OUT_W  = 24;
  localparam int unsigned BOUND_W    = 24;
  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned RATE_W     = 10;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam int unsigned MS_PER_S   = 1000;
  localparam int unsigned Q8_ONE     = 256;
  localparam int unsigned Q8_SHIFT   = 8;
  localparam int unsigned FRAC_ONE   = 65536;
  localparam int unsigned FRAC_SHIFT = 16;

  // frame period = PERIOD_NUM / (frame_rate * |speed|)
  localparam int unsigned PERIOD_NUM = MS_PER_S * Q8_ONE;
  localparam int unsigned NUM_W      = $clog2(PERIOD_NUM + 1);
  localparam int unsigned DEN_W      = RATE_W + SPEED_W;
  localparam int unsigned STEP_W     = STAMP_W + SPEED_W - Q8_SHIFT;

  // commands
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PLAY   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PAUSE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_STOP   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TOGGLE = 3'd4;
  localparam logic [CMD_W-1:0] CMD_PLACE  = 3'd5;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_START = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_STOP  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_SPEED = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_RATE  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_LOOP  = 3'd4;

  // register reset values
  localparam logic [BOUND_W-1:0]        START_RST = 24'd0;
  localparam logic [BOUND_W-1:0]        STOP_RST  = 24'd1000;
  localparam logic signed [SPEED_W-1:0] SPEED_RST = 16'sd256;
  localparam logic [RATE_W-1:0]         RATE_RST  = 10'd30;
  localparam logic                      LOOP_RST  = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic mul_en;
    logic div_start;
    logic apply_en;
    logic finish_en;
    logic out_load;
  } aph_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic div_busy;
    logic out_free;
  } aph_stat_t;

endpackage

### rtl/aph_in_if.sv
// command channel: valid/ready handshake with the command payload
// depends on aph_pkg
interface aph_in_if;
  import aph_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [STAMP_W-1:0] now_ms;
  logic [FRAC_W-1:0]  place_frac;

  modport source (output valid, cmd, now_ms, place_frac, input ready);
  modport sink   (input valid, cmd, now_ms, place_frac, output ready);
endinterface

### rtl/aph_out_if.sv
// result channel: valid/ready handshake with the playback status payload
// depends on aph_pkg
interface aph_out_if;
  import aph_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [POS_OUT_W-1:0] position_ms;
  logic                 new_frame;
  logic                 finished;
  logic                 running;

  modport source (output valid, position_ms, new_frame, finished, running, input ready);
  modport sink   (input valid, position_ms, new_frame, finished, running, output ready);
endinterface

### rtl/aph_div.sv
// restoring divider for the frame period: constant dividend, one quotient bit a cycle
// depends on aph_pkg
module aph_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [aph_pkg::DEN_W-1:0]  divisor_i,
  output logic                       busy_o,
  output logic [aph_pkg::NUM_W-1:0]  quot_o
);
  import aph_pkg::*;

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [NUM_W-1:0] quot_q, quot_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] dvs_q, dvs_d;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem_q, num_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
      num_d  = NUM_W'(PERIOD_NUM);
      quot_d = '0;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      num_d  = {num_q[NUM_W-2:0], 1'b0};
      quot_d = {quot_q[NUM_W-2:0], ge};
      rem_d  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

### rtl/aph_ctrl.sv
// sequencing state machine: accept, multiply, divide (ticks only), apply, finish, emit
// depends on aph_pkg
module aph_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  aph_pkg::aph_stat_t stat_i,
  output aph_pkg::aph_ctl_t  ctl_o
);
  import aph_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_MUL    = 6'b000010,
    ST_DIV    = 6'b000100,
    ST_APPLY  = 6'b001000,
    ST_FINISH = 6'b010000,
    ST_EMIT   = 6'b100000
  } aph_state_e;

  aph_state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.load_in = 1'b1;
          state_d       = ST_MUL;
        end
      end
      ST_MUL: begin
        ctl_o.mul_en = 1'b1;
        if (stat_i.is_tick) begin
          ctl_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end else begin
          state_d = ST_APPLY;
        end
      end
      ST_DIV: begin
        if (!stat_i.div_busy) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        ctl_o.apply_en = 1'b1;
        state_d        = ST_FINISH;
      end
      ST_FINISH: begin
        ctl_o.finish_en = 1'b1;
        state_d         = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          ctl_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/aph_datapath.sv
// playhead datapath: settings, playback state, step and period arithmetic, result register
// depends on aph_pkg and aph_div
module aph_datapath #(
  parameter int unsigned TIME_BITS = aph_pkg::TIME_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  aph_pkg::aph_ctl_t               ctl_i,
  output aph_pkg::aph_stat_t              stat_o,
  input  logic                            cfg_we_i,
  input  logic [aph_pkg::CFG_ADDR_W-1:0]  cfg_idx_i,
  input  logic [aph_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [aph_pkg::CMD_W-1:0]       cmd_i,
  input  logic [aph_pkg::STAMP_W-1:0]     now_ms_i,
  input  logic [aph_pkg::FRAC_W-1:0]      place_frac_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [aph_pkg::POS_OUT_W-1:0]   position_ms_o,
  output logic                            new_frame_o,
  output logic                            finished_o,
  output logic                            running_o
);
  import aph_pkg::*;

  localparam int unsigned PX_W  = STAMP_W + 1;
  localparam int unsigned SUM_W = STEP_W + 1;
  localparam logic [PX_W-1:0]      POS_MAX_X = (PX_W'(1) << TIME_BITS) - PX_W'(1);
  localparam logic [TIME_BITS-1:0] POS_MAX   = '1;

  // settings
  logic [BOUND_W-1:0]        start_q, stop_q;
  logic signed [SPEED_W-1:0] speed_q;
  logic [RATE_W-1:0]         rate_q;
  logic                      loop_q;

  // playback state
  logic [TIME_BITS-1:0] cur_pos_q, cur_pos_d;
  logic [STAMP_W-1:0]   last_stamp_q, last_stamp_d;
  logic                 stamp_valid_q, stamp_valid_d;
  logic [STAMP_W-1:0]   accum_q, accum_d;
  logic                 playing_q, playing_d;
  logic                 done_q, done_d;
  logic                 flag_q, flag_d;
  logic                 under_q, under_d;

  // accepted item and intermediate products
  logic [CMD_W-1:0]   cmd_q;
  logic [STAMP_W-1:0] now_q;
  logic [FRAC_W-1:0]  frac_q;
  logic [STEP_W-1:0]  step_q;
  logic [STAMP_W-1:0] acc_sum_q;
  logic [BOUND_W-1:0] place_off_q;
  logic               frac_full_q;
  logic               den_zero_q;

  // result register
  logic                 out_valid_q, out_valid_d;
  logic [POS_OUT_W-1:0] res_pos_q;
  logic                 res_flag_q, res_done_q, res_play_q;

  logic [SPEED_W-1:0]             mag;
  logic                           fwd;
  logic [PX_W-1:0]                start_x, stop_x;
  logic [TIME_BITS-1:0]           lo, hi;
  logic                           restart;
  logic [STAMP_W-1:0]             base, delta;
  logic [STAMP_W+SPEED_W-1:0]     step_prod;
  logic [STAMP_W-1:0]             acc0;
  logic [PX_W-1:0]                acc_x;
  logic [STAMP_W-1:0]             acc_sat;
  logic                           down;
  logic [BOUND_W-1:0]             span;
  logic [FRAC_W-1:0]              frac_lim;
  logic [FRAC_W+BOUND_W-1:0]      place_prod;
  logic [DEN_W-1:0]               den;
  logic [NUM_W-1:0]               period;
  logic                           div_busy;
  logic [TIME_BITS-1:0]           pos0;
  logic [SUM_W-1:0]               fwd_sum;
  logic [TIME_BITS-1:0]           fwd_pos;
  logic                           under;
  logic [TIME_BITS-1:0]           back_pos;
  logic                           frame_hit;
  logic [BOUND_W-1:0]             place_t;
  logic [PX_W-1:0]                place_x;
  logic [TIME_BITS-1:0]           place_pos;
  logic [PX_W-1:0]                pos_x;

  // bounds limited to the position range
  assign mag     = speed_q[SPEED_W-1] ? SPEED_W'(-speed_q) : SPEED_W'(speed_q);
  assign fwd     = ~speed_q[SPEED_W-1];
  assign start_x = PX_W'(start_q);
  assign stop_x  = PX_W'(stop_q);
  assign lo      = (start_x > POS_MAX_X) ? POS_MAX : TIME_BITS'(start_x);
  assign hi      = (stop_x > POS_MAX_X) ? POS_MAX : TIME_BITS'(stop_x);
  assign restart = done_q & loop_q;

  // multiply stage
  assign base      = stamp_valid_q ? last_stamp_q : now_q;
  assign delta     = now_q - base;
  assign step_prod = (STAMP_W+SPEED_W)'(delta) * (STAMP_W+SPEED_W)'(mag);
  assign acc0      = restart ? '0 : accum_q;
  assign acc_x     = PX_W'(acc0) + PX_W'(delta);
  assign acc_sat   = acc_x[STAMP_W] ? '1 : acc_x[STAMP_W-1:0];
  assign down      = stop_q < start_q;
  assign span      = down ? (start_q - stop_q) : (stop_q - start_q);
  assign frac_lim  = (frac_q > FRAC_W'(FRAC_ONE)) ? FRAC_W'(FRAC_ONE) : frac_q;
  assign place_prod = (FRAC_W+BOUND_W)'(frac_lim) * (FRAC_W+BOUND_W)'(span);
  assign den       = DEN_W'(rate_q) * DEN_W'(mag);

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_in) begin
      cmd_q  <= cmd_i;
      now_q  <= now_ms_i;
      frac_q <= place_frac_i;
    end
    if (ctl_i.mul_en) begin
      step_q      <= step_prod[STAMP_W+SPEED_W-1:Q8_SHIFT];
      acc_sum_q   <= acc_sat;
      place_off_q <= place_prod[FRAC_SHIFT+BOUND_W-1:FRAC_SHIFT];
      frac_full_q <= frac_q >= FRAC_W'(FRAC_ONE);
      den_zero_q  <= (rate_q == '0) || (mag == '0);
    end
  end

  aph_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (ctl_i.div_start),
    .divisor_i (den),
    .busy_o    (div_busy),
    .quot_o    (period)
  );

  // apply stage
  assign pos0      = restart ? (fwd ? lo : hi) : cur_pos_q;
  assign fwd_sum   = SUM_W'(pos0) + SUM_W'(step_q);
  assign fwd_pos   = (fwd_sum > SUM_W'(POS_MAX_X)) ? POS_MAX : TIME_BITS'(fwd_sum);
  assign under     = step_q > STEP_W'(pos0);
  assign back_pos  = under ? '0 : TIME_BITS'(STEP_W'(pos0) - step_q);
  assign frame_hit = !den_zero_q && (acc_sum_q >= STAMP_W'(period));
  assign place_t   = down ? (start_q - place_off_q) : (start_q + place_off_q);
  assign place_x   = PX_W'(place_t);
  assign place_pos = (place_x > POS_MAX_X) ? POS_MAX : TIME_BITS'(place_x);

  always_comb begin
    cur_pos_d     = cur_pos_q;
    last_stamp_d  = last_stamp_q;
    stamp_valid_d = stamp_valid_q;
    accum_d       = accum_q;
    playing_d     = playing_q;
    done_d        = done_q;
    flag_d        = flag_q;
    under_d       = under_q;

    if (ctl_i.apply_en) begin
      case (cmd_q)
        CMD_TICK: begin
          flag_d        = restart;
          stamp_valid_d = 1'b1;
          last_stamp_d  = now_q;
          under_d       = 1'b0;
          if (playing_q) begin
            if (fwd) begin
              cur_pos_d = fwd_pos;
            end else begin
              cur_pos_d = back_pos;
              under_d   = under;
            end
            if (frame_hit) begin
              accum_d = acc_sum_q - STAMP_W'(period);
              flag_d  = 1'b1;
            end else begin
              accum_d = acc_sum_q;
            end
          end else begin
            cur_pos_d = pos0;
            accum_d   = '0;
          end
        end
        CMD_PLAY: begin
          playing_d = 1'b1;
          if (done_q && !loop_q) begin
            cur_pos_d = fwd ? lo : hi;
          end
          done_d = 1'b0;
        end
        CMD_PAUSE: begin
          playing_d = 1'b0;
        end
        CMD_STOP: begin
          playing_d = 1'b0;
          accum_d   = '0;
        end
        CMD_TOGGLE: begin
          playing_d = ~playing_q;
        end
        CMD_PLACE: begin
          cur_pos_d     = place_pos;
          stamp_valid_d = 1'b0;
          accum_d       = '0;
        end
        default: ;
      endcase
    end

    // bound checks on the updated position
    if (ctl_i.finish_en) begin
      case (cmd_q)
        CMD_TICK: begin
          if (fwd ? (cur_pos_q >= hi) : (under_q || cur_pos_q < lo)) begin
            done_d    = 1'b1;
            cur_pos_d = fwd ? hi : lo;
            if (loop_q) begin
              flag_d = 1'b1;
            end
          end else begin
            done_d = 1'b0;
          end
        end
        CMD_PLACE: begin
          done_d = fwd ? ((cur_pos_q >= hi) || frac_full_q) : (cur_pos_q < lo);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q       <= START_RST;
      stop_q        <= STOP_RST;
      speed_q       <= SPEED_RST;
      rate_q        <= RATE_RST;
      loop_q        <= LOOP_RST;
      cur_pos_q     <= '0;
      last_stamp_q  <= '0;
      stamp_valid_q <= 1'b0;
      accum_q       <= '0;
      playing_q     <= 1'b1;
      done_q        <= 1'b0;
      flag_q        <= 1'b0;
      under_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_START: start_q <= cfg_data_i[BOUND_W-1:0];
          REG_STOP:  stop_q  <= cfg_data_i[BOUND_W-1:0];
          REG_SPEED: speed_q <= signed'(cfg_data_i[SPEED_W-1:0]);
          REG_RATE:  rate_q  <= cfg_data_i[RATE_W-1:0];
          REG_LOOP:  loop_q  <= cfg_data_i[0];
          default: ;
        endcase
      end
      cur_pos_q     <= cur_pos_d;
      last_stamp_q  <= last_stamp_d;
      stamp_valid_q <= stamp_valid_d;
      accum_q       <= accum_d;
      playing_q     <= playing_d;
      done_q        <= done_d;
      flag_q        <= flag_d;
      under_q       <= under_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // result register
  assign pos_x = PX_W'(cur_pos_q);

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      res_pos_q  <= pos_x[POS_OUT_W-1:0];
      res_flag_q <= flag_q;
      res_done_q <= done_q;
      res_play_q <= playing_q;
    end
  end

  assign stat_o.is_tick  = (cmd_q == CMD_TICK);
  assign stat_o.div_busy = div_busy;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign position_ms_o = res_pos_q;
  assign new_frame_o   = res_flag_q;
  assign finished_o    = res_done_q;
  assign running_o     = res_play_q;

endmodule

### rtl/animation_playhead_timer.sv
// Playback-position timer for an animation clip. Each command transfer on in_i yields exactly
// one status transfer on out_o (position, new-frame, finished, running). A tick passes, in
// order, through a multiply step, a restoring divider that forms the frame period 256000 /
// (frame_rate * |speed|) one quotient bit per cycle, a wait state that sees the divider
// finish, the apply and finish update steps, the load of the status register and a return
// to idle to take the next command. Play, pause, stop, toggle and set position skip the
// divider. A status that out_o holds off stalls only the load of the following status. The
// next command is taken while a finished status still waits on out_o.
// Settings are to be written through cfg_we_i / cfg_idx_i / cfg_data_i only while no
// command is in flight; the block itself does not enforce this. Indexes beyond the
// register list are ignored.
//
// top level: settings port, command and status channels
// depends on aph_pkg, aph_in_if, aph_out_if, aph_ctrl, aph_datapath
module animation_playhead_timer #(
  parameter int unsigned TIME_BITS = aph_pkg::TIME_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [aph_pkg::CFG_ADDR_W-1:0]  cfg_idx_i,
  input  logic [aph_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  aph_in_if.sink                          in_i,
  aph_out_if.source                       out_o
);
  import aph_pkg::*;

  aph_ctl_t  ctl;    // per-cycle commands from the sequencer
  aph_stat_t stat;   // command kind, divider and result-register status
  logic      in_ready;
  logic      out_valid;

  // sequencer: one command in flight at a time
  aph_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .ctl_o      (ctl)
  );

  // settings, playback state, arithmetic and the status output register
  aph_datapath #(
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (in_i.cmd),
    .now_ms_i      (in_i.now_ms),
    .place_frac_i  (in_i.place_frac),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_o.ready),
    .position_ms_o (out_o.position_ms),
    .new_frame_o   (out_o.new_frame),
    .finished_o    (out_o.finished),
    .running_o     (out_o.running)
  );

  // handshake wiring
  assign in_i.ready  = in_ready;
  assign out_o.valid = out_valid;

endmodule
